[hw/rtl/keyframe_linear_interpolator_defines.svh]
// ----------------------------------------------------------------------------
// Keyframe linear interpolator assertion macros
// Shared checking macros; they compile to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef KEYFRAME_LINEAR_INTERPOLATOR_DEFINES_SVH
`define KEYFRAME_LINEAR_INTERPOLATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define KLI_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define KLI_NEVER(name, cond, msg) `KLI_ASSERT(name, !(cond), msg)
`else
`define KLI_ASSERT(name, prop, msg)
`define KLI_NEVER(name, cond, msg)
`endif
`endif

[hw/rtl/kli_pkg.sv]
// ----------------------------------------------------------------------------
// kli_pkg
// Constants and controller/datapath interface types of the keyframe player.
// ----------------------------------------------------------------------------
package kli_pkg;

	localparam int MAX_KEYFRAMES = 9;
	localparam int NUM_CH        = 8;
	localparam int CH_W          = 32;
	localparam int ROW_W         = NUM_CH * CH_W;
	localparam int STEP_W        = 16;
	localparam int FRAME_W       = $clog2(MAX_KEYFRAMES + 1);
	localparam int IDX_W         = $clog2(MAX_KEYFRAMES);
	localparam int STAT_W        = 4;
	localparam int OUT_BITS      = ROW_W + 1 + 2 * STAT_W;
	localparam int OUT_W         = ((OUT_BITS + 7) / 8) * 8;
	localparam int DIV_CNT_W     = $clog2(CH_W);
	localparam logic [STEP_W-1:0] STEPS_RESET = 16'd190;

	typedef enum logic [1:0] {
		REQ_SAVE = 2'd0,
		REQ_PLAY = 2'd1,
		REQ_TICK = 2'd2,
		REQ_NONE = 2'd3
	} req_t;

	typedef struct packed {
		logic              save;
		logic [IDX_W-1:0]  wr_addr;
		logic [IDX_W-1:0]  rd_addr;
		logic              latch_a;
		logic              load_pose_row;
		logic              div_start;
		logic              div_step;
		logic              div_write;
		logic              add_inc;
		logic              load_out;
		logic              playing;
		logic [STAT_W-1:0] segment;
		logic [STAT_W-1:0] frames;
		logic [STEP_W-1:0] divisor;
	} cmd_t;

	typedef struct packed {
		logic div_last;
	} stat_t;

endpackage

[hw/rtl/keyframe_linear_interpolator.sv]
// ----------------------------------------------------------------------------
// keyframe_linear_interpolator
// Eight-channel Q16.16 keyframe recorder and linear playback engine.
// ----------------------------------------------------------------------------
// Channel   Handshake                   Content
// s_axis    s_axis_tvalid/tready        tuser request, tdata eight input channels
// m_axis    m_axis_tvalid/tready        tdata pose, playing, segment, frame count
// cfg       cfg_valid/cfg_ready         cfg_data steps per segment
//
// Save, stop, idle tick and stepping tick go from ST_IDLE to ST_DONE, where the
// result is registered. A segment start (play or segment change) passes ST_RD_B,
// ST_DIV_LD, ST_DIV (restoring division in all eight lanes at once), ST_DIV_WR.
// One request is in work at a time; a pending result does not block the next
// transfer. Reset clears the control state; keyframe memory is not cleared.
// ----------------------------------------------------------------------------
module keyframe_linear_interpolator (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	// tdata: in_pos_x, in_pos_y, in_pos_z, in_heading, in_joint_a..in_joint_d
	input  logic [kli_pkg::ROW_W-1:0]  s_axis_tdata,
	// tuser: req_type
	input  logic [1:0]                 s_axis_tuser,
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	// tdata: out_pos_x..out_joint_d, playing, segment_now, frames_stored, zero pad
	output logic [kli_pkg::OUT_W-1:0]  m_axis_tdata,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [kli_pkg::STEP_W-1:0] cfg_data
);

	kli_pkg::cmd_t  cmd;
	kli_pkg::stat_t stat;

	kli_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.cmd           (cmd),
		.stat          (stat)
	);

	kli_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tdata (s_axis_tdata),
		.cmd          (cmd),
		.stat         (stat),
		.m_axis_tdata (m_axis_tdata)
	);

endmodule

[hw/rtl/kli_datapath.sv]
// ----------------------------------------------------------------------------
// kli_datapath
// Keyframe memory, pose and increment registers, eight divider lanes, output.
// ----------------------------------------------------------------------------
module kli_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [kli_pkg::ROW_W-1:0]  s_axis_tdata,
	input  kli_pkg::cmd_t              cmd,
	output kli_pkg::stat_t             stat,
	output logic [kli_pkg::OUT_W-1:0]  m_axis_tdata
);

	localparam int CW = kli_pkg::CH_W;
	localparam int SW = kli_pkg::STEP_W;

	logic [kli_pkg::ROW_W-1:0] mem [kli_pkg::MAX_KEYFRAMES];
	logic [kli_pkg::ROW_W-1:0] rd_q;
	logic [kli_pkg::ROW_W-1:0] row_a_q;
	logic [CW-1:0]             pose_q [kli_pkg::NUM_CH];
	logic [CW-1:0]             inc_q  [kli_pkg::NUM_CH];
	logic [SW-1:0]             rem_q  [kli_pkg::NUM_CH];
	logic [CW-1:0]             quo_q  [kli_pkg::NUM_CH];
	logic                      neg_q  [kli_pkg::NUM_CH];
	logic [kli_pkg::DIV_CNT_W-1:0] div_cnt_q;
	logic [kli_pkg::ROW_W-1:0] pose_flat;
	logic [kli_pkg::OUT_W-1:0] out_q;

	function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] p, input logic [CW-1:0] i);
		logic [CW:0] sum;
		sum = {p[CW-1], p} + {i[CW-1], i};
		if (sum[CW] != sum[CW-1]) begin
			sat_add = sum[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
		end else begin
			sat_add = sum[CW-1:0];
		end
	endfunction

	// Applies the sign to the unsigned quotient and clamps to the signed range.
	function automatic logic [CW-1:0] sat_quo(input logic [CW-1:0] q, input logic neg);
		if (neg) begin
			sat_quo = (q > {1'b1, {(CW-1){1'b0}}}) ? {1'b1, {(CW-1){1'b0}}} : (~q + 1'b1);
		end else begin
			sat_quo = q[CW-1] ? {1'b0, {(CW-1){1'b1}}} : q;
		end
	endfunction

	always_ff @(posedge clk) begin
		if (cmd.save) begin
			mem[cmd.wr_addr] <= s_axis_tdata;
		end
		rd_q <= mem[cmd.rd_addr];
		if (cmd.latch_a) begin
			row_a_q <= rd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (cmd.div_start) begin
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			div_cnt_q <= div_cnt_q + 1'b1;
		end
	end

	assign stat.div_last = (div_cnt_q == kli_pkg::DIV_CNT_W'(CW - 1));

	for (genvar ch = 0; ch < kli_pkg::NUM_CH; ch++) begin : g_lane
		logic [CW:0]   diff;
		logic [CW:0]   mag;
		logic [SW:0]   trial;
		logic [SW:0]   trial_sub;
		logic          ge;

		assign diff      = {rd_q[ch*CW+CW-1], rd_q[ch*CW +: CW]}
		                 - {row_a_q[ch*CW+CW-1], row_a_q[ch*CW +: CW]};
		assign mag       = diff[CW] ? (~diff + 1'b1) : diff;
		assign trial     = {rem_q[ch], quo_q[ch][CW-1]};
		assign ge        = (trial >= {1'b0, cmd.divisor});
		assign trial_sub = trial - {1'b0, cmd.divisor};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				pose_q[ch] <= '0;
				inc_q[ch]  <= '0;
			end else begin
				if (cmd.save) begin
					pose_q[ch] <= s_axis_tdata[ch*CW +: CW];
				end else if (cmd.load_pose_row) begin
					pose_q[ch] <= rd_q[ch*CW +: CW];
				end else if (cmd.add_inc) begin
					pose_q[ch] <= sat_add(pose_q[ch], inc_q[ch]);
				end
				if (cmd.div_write) begin
					inc_q[ch] <= sat_quo(quo_q[ch], neg_q[ch]);
				end
			end
		end

		// Restoring division, one quotient bit per cycle.
		always_ff @(posedge clk) begin
			if (cmd.div_start) begin
				rem_q[ch] <= '0;
				quo_q[ch] <= mag[CW-1:0];
				neg_q[ch] <= diff[CW];
			end else if (cmd.div_step) begin
				quo_q[ch] <= {quo_q[ch][CW-2:0], ge};
				rem_q[ch] <= ge ? trial_sub[SW-1:0] : trial[SW-1:0];
			end
		end

		assign pose_flat[ch*CW +: CW] = pose_q[ch];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q <= {{(kli_pkg::OUT_W - kli_pkg::OUT_BITS){1'b0}},
			          cmd.frames, cmd.segment, cmd.playing, pose_flat};
		end
	end

	assign m_axis_tdata = out_q;

endmodule

[hw/rtl/kli_ctrl.sv]
// ----------------------------------------------------------------------------
// kli_ctrl
// Request decoder and sequencer: counters, play state and handshakes.
// ----------------------------------------------------------------------------
`include "keyframe_linear_interpolator_defines.svh"

module kli_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [1:0]                 s_axis_tuser,
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [kli_pkg::STEP_W-1:0] cfg_data,
	output kli_pkg::cmd_t              cmd,
	input  kli_pkg::stat_t             stat
);

	localparam int FW = kli_pkg::FRAME_W;
	localparam int IW = kli_pkg::IDX_W;
	localparam logic [FW-1:0] FRAME_MAX  = FW'(kli_pkg::MAX_KEYFRAMES);
	localparam logic [FW-1:0] TWO_FRAMES = FW'(2);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_B,
		ST_DIV_LD,
		ST_DIV,
		ST_DIV_WR,
		ST_DONE
	} state_t;

	state_t                    state_q;
	logic [FW-1:0]             frame_q;
	logic [IW-1:0]             seg_q;
	logic [kli_pkg::STEP_W-1:0] step_q;
	logic [kli_pkg::STEP_W-1:0] steps_q;
	logic                      play_q;
	logic                      start_q;
	logic                      out_valid_q;

	kli_pkg::req_t             req;
	logic                      accept;
	logic [kli_pkg::STEP_W-1:0] eff_steps;
	logic                      frame_full;
	logic                      can_start;
	logic                      seg_end;
	logic [FW:0]               seg_next;
	logic [FW:0]               seg_plus2;
	logic                      seg_stop;
	logic [FW+kli_pkg::STAT_W-1:0] frame_ext;
	logic [IW+kli_pkg::STAT_W-1:0] seg_ext;

	assign req        = kli_pkg::req_t'(s_axis_tuser);
	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept     = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign cfg_ready  = 1'b1;
	assign eff_steps  = (steps_q == '0) ? kli_pkg::STEP_W'(1) : steps_q;
	assign frame_full = (frame_q == FRAME_MAX);
	assign can_start  = !play_q && (frame_q >= TWO_FRAMES);
	assign seg_end    = (step_q >= eff_steps);
	assign seg_next   = (FW+1)'(seg_q) + 1'b1;
	assign seg_plus2  = (FW+1)'(seg_q) + (FW+1)'(2);
	// Running past the last segment: next index plus two exceeds the frame count.
	assign seg_stop   = ((seg_next + (FW+1)'(2)) > {1'b0, frame_q});
	assign frame_ext  = {{kli_pkg::STAT_W{1'b0}}, frame_q};
	assign seg_ext    = {{kli_pkg::STAT_W{1'b0}}, seg_q};

	always_comb begin
		cmd               = '0;
		cmd.wr_addr       = frame_q[IW-1:0];
		cmd.playing       = play_q;
		cmd.segment       = seg_ext[kli_pkg::STAT_W-1:0];
		cmd.frames        = frame_ext[kli_pkg::STAT_W-1:0];
		cmd.divisor       = eff_steps;
		case (state_q)
			ST_IDLE: begin
				cmd.rd_addr = (req == kli_pkg::REQ_PLAY) ? '0 : seg_next[IW-1:0];
				cmd.save    = accept && (req == kli_pkg::REQ_SAVE) && !frame_full;
				cmd.add_inc = accept && (req == kli_pkg::REQ_TICK) && play_q && !seg_end;
			end
			ST_RD_B: begin
				cmd.rd_addr       = seg_q + IW'(1);
				cmd.latch_a       = 1'b1;
				cmd.load_pose_row = start_q;
			end
			ST_DIV_LD: cmd.div_start = 1'b1;
			ST_DIV:    cmd.div_step  = 1'b1;
			ST_DIV_WR: cmd.div_write = 1'b1;
			ST_DONE:   cmd.load_out  = !out_valid_q || m_axis_tready;
			default:   cmd.load_out  = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			frame_q     <= '0;
			seg_q       <= '0;
			step_q      <= '0;
			steps_q     <= kli_pkg::STEPS_RESET;
			play_q      <= 1'b0;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				steps_q <= cfg_data;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_DONE;
						case (req)
							kli_pkg::REQ_SAVE: begin
								if (!frame_full) begin
									frame_q <= frame_q + 1'b1;
								end
							end
							kli_pkg::REQ_PLAY: begin
								if (can_start) begin
									seg_q   <= '0;
									step_q  <= '0;
									start_q <= 1'b1;
									play_q  <= 1'b1;
									state_q <= ST_RD_B;
								end else begin
									play_q <= 1'b0;
								end
							end
							kli_pkg::REQ_TICK: begin
								if (play_q) begin
									if (!seg_end) begin
										step_q <= step_q + 1'b1;
									end else if (seg_stop) begin
										seg_q  <= '0;
										play_q <= 1'b0;
									end else begin
										seg_q   <= seg_next[IW-1:0];
										step_q  <= '0;
										start_q <= 1'b0;
										state_q <= ST_RD_B;
									end
								end
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_RD_B:   state_q <= ST_DIV_LD;
				ST_DIV_LD: state_q <= ST_DIV;
				ST_DIV: begin
					if (stat.div_last) begin
						state_q <= ST_DIV_WR;
					end
				end
				ST_DIV_WR: state_q <= ST_DONE;
				ST_DONE: begin
					if (cmd.load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`KLI_ASSERT(a_play_needs_two, play_q |-> (frame_q >= TWO_FRAMES), "playing with fewer than two frames")
	`KLI_ASSERT(a_seg_in_range, play_q |-> (seg_plus2 <= {1'b0, frame_q}), "segment beyond last frame")
	`KLI_NEVER(a_frame_bound, frame_q > FRAME_MAX, "frame count exceeds table depth")
	`KLI_ASSERT(a_busy_after_accept, accept |=> !s_axis_tready, "input taken again without processing")
	`KLI_NEVER(a_out_overwrite, cmd.load_out && out_valid_q && !m_axis_tready, "result overwritten")

endmodule
